[hw/rtl/ssprx_pkg.sv]
// Shared types, codes and constants for the servo status packet receiver.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps

package ssprx_pkg;

  // Tick counter width; timeout_ticks is cut or zero-extended to this width.
  localparam int TIMER_WIDTH = 16;
  localparam int TICKS_W     = 16;
  localparam int TICKS_EXT_W = 32;

  // Framing constants.
  localparam logic [7:0] HDR_BYTE      = 8'hFF;
  localparam logic [7:0] MIN_LEN       = 8'd6;
  localparam logic [7:0] LEN_BIAS      = 8'd4;
  localparam logic [7:0] PAYLOAD_START = 8'd5;
  localparam logic [7:0] SUM_GOOD      = 8'hFF;

  // Byte positions inside the packet.
  localparam logic [7:0] POS_ID    = 8'd2;
  localparam logic [7:0] POS_LEN   = 8'd3;
  localparam logic [7:0] POS_ERR   = 8'd4;
  localparam logic [1:0] HDR_DONE  = 2'd2;
  localparam logic [1:0] HDR_ONE   = 2'd1;

  // Stream widths.
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [0:0] {
    PH_IDLE = 1'b0,
    PH_RECV = 1'b1
  } phase_t;

  typedef enum logic [2:0] {
    FAIL_NONE     = 3'd0,
    FAIL_TIMEOUT  = 3'd1,
    FAIL_ID       = 3'd2,
    FAIL_LEN      = 3'd3,
    FAIL_CHECKSUM = 3'd4
  } fail_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_DONE    = 1'b1;

  // One accepted input item.
  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         servo_id;
    logic [7:0]         expected_len;
    logic [TICKS_W-1:0] timeout_ticks;
    logic [7:0]         rx_byte;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       result_kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       success;
    logic [2:0] fail_cause;
    logic [7:0] payload_count;
  } result_t;

endpackage

[hw/rtl/ssprx_in_reg.sv]
// Input register of the servo status packet receiver.
// Holds one accepted item until the framing core takes it; uses ssprx_pkg.
`timescale 1ns / 1ps

module ssprx_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                take,
  input  ssprx_pkg::item_t    item_in,
  output logic                item_valid,
  output ssprx_pkg::item_t    item
);

  // Valid flag: set on load, cleared when the core takes the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

[hw/rtl/ssprx_frame_core.sv]
// Framing core: transaction state, header hunt, byte count, checksum and timer.
// Produces at most one result per item taken; uses ssprx_pkg.
`timescale 1ns / 1ps

module ssprx_frame_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  ssprx_pkg::item_t     item,
  output logic                 res_fire,
  output ssprx_pkg::result_t   res
);

  localparam int TW = ssprx_pkg::TIMER_WIDTH;

  ssprx_pkg::phase_t phase, phase_next;
  logic [1:0]        header_seen, header_seen_next;
  logic [7:0]        byte_count, byte_count_next;
  logic [7:0]        want_id, want_id_next;
  logic [7:0]        want_len, want_len_next;
  logic [7:0]        sum_acc, sum_acc_next;
  logic              id_ok, id_ok_next;
  logic              len_ok, len_ok_next;
  logic [TW-1:0]     tick_count, tick_count_next;
  logic [TW-1:0]     tick_limit, tick_limit_next;

  logic [ssprx_pkg::TICKS_EXT_W-1:0] ticks_ext;
  logic [TW-1:0]     tick_inc;
  logic [7:0]        sum_plus;
  logic [8:0]        count_plus;
  logic [7:0]        b;
  logic [2:0]        cause;

  assign ticks_ext  = {{(ssprx_pkg::TICKS_EXT_W - ssprx_pkg::TICKS_W){1'b0}},
                       item.timeout_ticks};
  assign b          = item.rx_byte;
  assign sum_plus   = sum_acc + b;
  assign count_plus = {1'b0, byte_count} + 9'd1;
  assign tick_inc   = (tick_count != {TW{1'b1}}) ? tick_count + {{(TW-1){1'b0}}, 1'b1}
                                                 : tick_count;

  // Failure cause for the closing byte, in priority order.
  always_comb begin
    if (!id_ok) begin
      cause = ssprx_pkg::FAIL_ID;
    end else if (!len_ok) begin
      cause = ssprx_pkg::FAIL_LEN;
    end else if (sum_plus != ssprx_pkg::SUM_GOOD) begin
      cause = ssprx_pkg::FAIL_CHECKSUM;
    end else begin
      cause = ssprx_pkg::FAIL_NONE;
    end
  end

  // Next state and result for the item being taken.
  always_comb begin
    phase_next       = phase;
    header_seen_next = header_seen;
    byte_count_next  = byte_count;
    want_id_next     = want_id;
    want_len_next    = want_len;
    sum_acc_next     = sum_acc;
    id_ok_next       = id_ok;
    len_ok_next      = len_ok;
    tick_count_next  = tick_count;
    tick_limit_next  = tick_limit;
    res_fire         = 1'b0;
    res              = '0;

    if (take) begin
      unique case (item.opcode)
        ssprx_pkg::OP_ARM: begin
          want_id_next     = item.servo_id;
          want_len_next    = (item.expected_len < ssprx_pkg::MIN_LEN) ?
                             ssprx_pkg::MIN_LEN : item.expected_len;
          tick_limit_next  = ticks_ext[TW-1:0];
          tick_count_next  = '0;
          sum_acc_next     = '0;
          id_ok_next       = 1'b0;
          len_ok_next      = 1'b0;
          header_seen_next = '0;
          byte_count_next  = '0;
          phase_next       = ssprx_pkg::PH_RECV;
        end
        ssprx_pkg::OP_BYTE: begin
          if (phase == ssprx_pkg::PH_RECV) begin
            if (header_seen != ssprx_pkg::HDR_DONE) begin
              // Header hunt: only 0xFF bytes count.
              if (b == ssprx_pkg::HDR_BYTE) begin
                header_seen_next = header_seen + 2'd1;
                byte_count_next  = {6'd0, header_seen + 2'd1};
              end
            end else if (byte_count == ssprx_pkg::POS_ID) begin
              if (b == ssprx_pkg::HDR_BYTE) begin
                // Extra header byte where the id should be.
                header_seen_next = ssprx_pkg::HDR_ONE;
                byte_count_next  = 8'd1;
              end else begin
                sum_acc_next    = b;
                id_ok_next      = (b == want_id);
                byte_count_next = ssprx_pkg::POS_LEN;
              end
            end else if (byte_count == ssprx_pkg::POS_LEN) begin
              sum_acc_next    = sum_plus;
              len_ok_next     = (b == want_len - ssprx_pkg::LEN_BIAS);
              byte_count_next = ssprx_pkg::POS_ERR;
            end else if (byte_count == ssprx_pkg::POS_ERR) begin
              sum_acc_next    = sum_plus;
              byte_count_next = ssprx_pkg::PAYLOAD_START;
            end else if (count_plus < {1'b0, want_len}) begin
              // Tentative payload byte.
              sum_acc_next     = sum_plus;
              byte_count_next  = count_plus[7:0];
              res_fire         = 1'b1;
              res.result_kind  = ssprx_pkg::KIND_PAYLOAD;
              res.data_byte    = b;
              res.byte_index   = byte_count - ssprx_pkg::PAYLOAD_START;
            end else begin
              // Checksum byte closes the transaction.
              sum_acc_next     = sum_plus;
              phase_next       = ssprx_pkg::PH_IDLE;
              header_seen_next = '0;
              byte_count_next  = '0;
              res_fire         = 1'b1;
              res.result_kind  = ssprx_pkg::KIND_DONE;
              res.fail_cause   = cause;
              if (cause == ssprx_pkg::FAIL_NONE) begin
                res.success       = 1'b1;
                res.payload_count = want_len - ssprx_pkg::MIN_LEN;
              end
            end
          end
        end
        ssprx_pkg::OP_TICK: begin
          if (phase == ssprx_pkg::PH_RECV && tick_limit != '0) begin
            tick_count_next = tick_inc;
            if (tick_inc >= tick_limit) begin
              phase_next       = ssprx_pkg::PH_IDLE;
              header_seen_next = '0;
              byte_count_next  = '0;
              res_fire         = 1'b1;
              res.result_kind  = ssprx_pkg::KIND_DONE;
              res.fail_cause   = ssprx_pkg::FAIL_TIMEOUT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= ssprx_pkg::PH_IDLE;
      header_seen <= '0;
      byte_count  <= '0;
    end else begin
      phase       <= phase_next;
      header_seen <= header_seen_next;
      byte_count  <= byte_count_next;
    end
  end

  // Transaction data, always loaded on arm before it is read.
  always_ff @(posedge clk) begin
    want_id    <= want_id_next;
    want_len   <= want_len_next;
    sum_acc    <= sum_acc_next;
    id_ok      <= id_ok_next;
    len_ok     <= len_ok_next;
    tick_count <= tick_count_next;
    tick_limit <= tick_limit_next;
  end

endmodule

[hw/rtl/ssprx_out_reg.sv]
// Result register of the servo status packet receiver.
// Holds one result item until the downstream side takes it; uses ssprx_pkg.
`timescale 1ns / 1ps

module ssprx_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  ssprx_pkg::result_t   res_in,
  input  logic                 ready,
  output logic                 res_valid,
  output ssprx_pkg::result_t   res
);

  // Valid flag: a load wins over a completed handoff in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

[hw/rtl/servo_status_packet_receiver_unit.sv]
// Top level of the servo status packet receiver: stream ports, input register,
// framing core and result register. Uses ssprx_pkg and the ssprx_* modules.
//
//   Channel  Dir  tdata (low bit up)                                  tuser
//   s_axis   in   servo_id 8, expected_len 8, timeout_ticks 16,       opcode 2
//                 rx_byte 8
//   m_axis   out  data_byte 8, byte_index 8, success 1, fail_cause 3,  result_kind 1
//                 payload_count 8, zero pad 4
//
// One item per cycle sustained while m_axis is not stalled. An accepted item is
// held in the input register, and the result it causes, if any, is then loaded
// into the result register, which drives m_axis_tvalid. The core takes an
// item only when the result register is empty or being emptied, so a stall on
// m_axis holds the input register and then s_axis_tready. Synchronous reset rst
// clears all valid flags and returns the receiver to idle with no transaction armed.
`timescale 1ns / 1ps

module servo_status_packet_receiver_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // servo_id [7:0], expected_len [15:8], timeout_ticks [31:16], rx_byte [39:32]
  input  logic [ssprx_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // opcode [1:0]
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // data_byte [7:0], byte_index [15:8], success [16], fail_cause [19:17],
  // payload_count [27:20], zero [31:28]
  output logic [ssprx_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // result_kind [0]
  output logic                                m_axis_tuser
);

  ssprx_pkg::item_t   item_in;
  ssprx_pkg::item_t   item;
  ssprx_pkg::result_t core_res;
  ssprx_pkg::result_t out_res;
  logic               item_valid;
  logic               in_load;
  logic               take;
  logic               out_free;
  logic               res_fire;

  // Unpack the incoming item.
  always_comb begin
    item_in.opcode        = s_axis_tuser;
    item_in.servo_id      = s_axis_tdata[7:0];
    item_in.expected_len  = s_axis_tdata[15:8];
    item_in.timeout_ticks = s_axis_tdata[31:16];
    item_in.rx_byte       = s_axis_tdata[39:32];
  end

  // Handshake between the stages.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign take          = item_valid && out_free;
  assign s_axis_tready = !item_valid || take;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  ssprx_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (in_load),
    .take       (take),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item       (item)
  );

  ssprx_frame_core u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .item     (item),
    .res_fire (res_fire),
    .res      (core_res)
  );

  ssprx_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_fire),
    .res_in    (core_res),
    .ready     (m_axis_tready),
    .res_valid (m_axis_tvalid),
    .res       (out_res)
  );

  // Pack the outgoing result item.
  assign m_axis_tuser = out_res.result_kind;
  assign m_axis_tdata = {4'b0000, out_res.payload_count, out_res.fail_cause,
                         out_res.success, out_res.byte_index, out_res.data_byte};

  // An empty input register always accepts.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_axis_tready)
    else $error("input register empty but s_axis_tready low");

  // A waiting item is not dropped while the result side is stalled.
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !out_free |=> item_valid && $stable(item))
    else $error("pending item lost during output stall");

  // A result is only loaded when the result register has room.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_fire |-> out_free)
    else $error("result register overwritten");

  // A successful done result carries no failure cause.
  a_success_clean: assert property (@(posedge clk) disable iff (rst)
    res_fire && core_res.success |->
      core_res.result_kind == ssprx_pkg::KIND_DONE &&
      core_res.fail_cause == ssprx_pkg::FAIL_NONE)
    else $error("success flagged with a failure cause");

endmodule

[test/servo_status_packet_receiver_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for servo_status_packet_receiver_unit: arm, byte and tick items
// go in over the input stream and every result is checked against a built-in framing model.
// Depends on ssprx_pkg and the receiver RTL.

module servo_status_packet_receiver_unit_tb;

  // Opcode value that the receiver has no meaning for.
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 400;

  // Framing model of the receiver plus the queue of results still owed by the block.
  class packet_scoreboard;
    ssprx_pkg::phase_t                 phase;
    logic [1:0]                        header_seen;
    logic [7:0]                        byte_count;
    logic [7:0]                        want_id;
    logic [7:0]                        want_len;
    logic [7:0]                        sum_acc;
    logic                              id_ok;
    logic                              len_ok;
    logic [ssprx_pkg::TIMER_WIDTH-1:0] tick_count;
    logic [ssprx_pkg::TIMER_WIDTH-1:0] tick_limit;
    ssprx_pkg::result_t                outcome_q[$];
    int                                failures;

    function new();
      go_idle();
      want_id    = '0;
      want_len   = '0;
      sum_acc    = '0;
      id_ok      = 1'b0;
      len_ok     = 1'b0;
      tick_count = '0;
      tick_limit = '0;
      failures   = 0;
    endfunction

    function void go_idle();
      phase       = ssprx_pkg::PH_IDLE;
      header_seen = '0;
      byte_count  = '0;
    endfunction

    // Appends one owed result at the tail of the queue.
    function void owe_result(ssprx_pkg::result_t r);
      outcome_q = {outcome_q, r};
    endfunction

    // Queues the result that closes a transaction.
    function void push_done(ssprx_pkg::fail_t cause);
      ssprx_pkg::result_t r;
      r             = '0;
      r.result_kind = ssprx_pkg::KIND_DONE;
      r.success     = (cause == ssprx_pkg::FAIL_NONE);
      r.fail_cause  = cause;
      if (cause == ssprx_pkg::FAIL_NONE) r.payload_count = want_len - ssprx_pkg::MIN_LEN;
      owe_result(r);
    endfunction

    // Advances the framing state by one received byte.
    function void frame_byte(logic [7:0] b);
      ssprx_pkg::result_t r;
      // Header hunt: anything but 0xFF is dropped.
      if (header_seen < ssprx_pkg::HDR_DONE) begin
        if (b == ssprx_pkg::HDR_BYTE) begin
          header_seen++;
          byte_count = {6'd0, header_seen};
        end
        return;
      end
      // Id slot: another 0xFF falls back to one header byte seen.
      if (byte_count == ssprx_pkg::POS_ID) begin
        if (b == ssprx_pkg::HDR_BYTE) begin
          header_seen = ssprx_pkg::HDR_ONE;
          byte_count  = {6'd0, ssprx_pkg::HDR_ONE};
        end else begin
          sum_acc    = b;
          id_ok      = (b == want_id);
          byte_count = ssprx_pkg::POS_LEN;
        end
        return;
      end
      sum_acc = sum_acc + b;
      if (byte_count == ssprx_pkg::POS_LEN) begin
        len_ok     = (b == want_len - ssprx_pkg::LEN_BIAS);
        byte_count = ssprx_pkg::POS_ERR;
      end else if (byte_count == ssprx_pkg::POS_ERR) begin
        byte_count = ssprx_pkg::PAYLOAD_START;
      end else if ({1'b0, byte_count} + 9'd1 < {1'b0, want_len}) begin
        r             = '0;
        r.result_kind = ssprx_pkg::KIND_PAYLOAD;
        r.data_byte   = b;
        r.byte_index  = byte_count - ssprx_pkg::PAYLOAD_START;
        owe_result(r);
        byte_count++;
      end else begin
        // Checksum byte: the checks close the transaction in priority order.
        go_idle();
        if (!id_ok) push_done(ssprx_pkg::FAIL_ID);
        else if (!len_ok) push_done(ssprx_pkg::FAIL_LEN);
        else if (sum_acc != ssprx_pkg::SUM_GOOD) push_done(ssprx_pkg::FAIL_CHECKSUM);
        else push_done(ssprx_pkg::FAIL_NONE);
      end
    endfunction

    // Notes one accepted input item and queues whatever result it causes.
    function void take_item(ssprx_pkg::item_t it);
      case (it.opcode)
        ssprx_pkg::OP_ARM: begin
          want_id     = it.servo_id;
          want_len    = (it.expected_len < ssprx_pkg::MIN_LEN) ?
                        ssprx_pkg::MIN_LEN : it.expected_len;
          tick_limit  = ssprx_pkg::TIMER_WIDTH'(it.timeout_ticks);
          tick_count  = '0;
          sum_acc     = '0;
          id_ok       = 1'b0;
          len_ok      = 1'b0;
          header_seen = '0;
          byte_count  = '0;
          phase       = ssprx_pkg::PH_RECV;
        end
        ssprx_pkg::OP_BYTE: begin
          if (phase == ssprx_pkg::PH_RECV) frame_byte(it.rx_byte);
        end
        ssprx_pkg::OP_TICK: begin
          if (phase == ssprx_pkg::PH_RECV && tick_limit != '0) begin
            if (tick_count != '1) tick_count++;
            if (tick_count >= tick_limit) begin
              go_idle();
              push_done(ssprx_pkg::FAIL_TIMEOUT);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Checks one accepted result item against the oldest one owed.
    function void check_outcome(ssprx_pkg::result_t got);
      ssprx_pkg::result_t want;
      if (outcome_q.size() == 0) begin
        $error("result item with none pending: result_kind %0d, data_byte %0d",
               got.result_kind, got.data_byte);
        failures++;
        return;
      end
      want = outcome_q.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("success", want.success, got.success);
      compare_field("fail_cause", want.fail_cause, got.fail_cause);
      compare_field("payload_count", want.payload_count, got.payload_count);
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ssprx_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [1:0]                      s_axis_tuser = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ssprx_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tuser;

  packet_scoreboard board = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int items_sent     = 0;
  int quiet_cycles   = 0;

  servo_status_packet_receiver_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk = ~clk;

  // The result side stalls at random.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Both handshakes are observed at the rising edge.
  always @(posedge clk) begin : monitor
    ssprx_pkg::item_t   it;
    ssprx_pkg::result_t res;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.opcode        = s_axis_tuser;
        it.servo_id      = s_axis_tdata[7:0];
        it.expected_len  = s_axis_tdata[15:8];
        it.timeout_ticks = s_axis_tdata[31:16];
        it.rx_byte       = s_axis_tdata[39:32];
        board.take_item(it);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        res.result_kind   = m_axis_tuser;
        res.data_byte     = m_axis_tdata[7:0];
        res.byte_index    = m_axis_tdata[15:8];
        res.success       = m_axis_tdata[16];
        res.fail_cause    = m_axis_tdata[19:17];
        res.payload_count = m_axis_tdata[27:20];
        board.check_outcome(res);
      end
    end
  end

  // Watchdog on cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one item, with random idle cycles first, and waits for its handshake.
  task automatic send_item(logic [1:0] op, logic [7:0] id, logic [7:0] len,
                           logic [15:0] ticks, logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {b, ticks, len, id};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Fields that an opcode does not use carry random values.
  task automatic send_byte(logic [7:0] b);
    send_item(ssprx_pkg::OP_BYTE, 8'($urandom), 8'($urandom), 16'($urandom), b);
  endtask

  task automatic send_tick();
    send_item(ssprx_pkg::OP_TICK, 8'($urandom), 8'($urandom), 16'($urandom),
              8'($urandom));
  endtask

  task automatic send_arm(logic [7:0] id, logic [7:0] len, logic [15:0] ticks);
    send_item(ssprx_pkg::OP_ARM, id, len, ticks, 8'($urandom));
  endtask

  // Sends a framed status packet with random error and payload bytes.
  task automatic send_status_packet(logic [7:0] id_byte, logic [7:0] len_byte,
                                    int n_payload, bit bad_sum, int tick_pct);
    logic [7:0] sum;
    logic [7:0] val;
    send_byte(ssprx_pkg::HDR_BYTE);
    send_byte(ssprx_pkg::HDR_BYTE);
    send_byte(id_byte);
    send_byte(len_byte);
    sum = id_byte + len_byte;
    val = 8'($urandom);
    send_byte(val);
    sum = sum + val;
    for (int i = 0; i < n_payload; i++) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      val = 8'($urandom);
      send_byte(val);
      sum = sum + val;
    end
    val = ~sum;
    if (bad_sum) val = val ^ 8'($urandom_range(255, 1));
    send_byte(val);
  endtask

  // One random transaction, mostly well formed, or a single stray item.
  task automatic random_transaction();
    logic [7:0]  id;
    logic [7:0]  len_req;
    logic [7:0]  full_len;
    logic [7:0]  id_byte;
    logic [7:0]  len_byte;
    logic [15:0] ticks;
    int          sel;
    int          n_payload;
    sel = $urandom_range(99);
    if (sel < 6) begin
      send_item(2'($urandom), 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom));
      return;
    end
    id  = ($urandom_range(49) == 0) ? ssprx_pkg::HDR_BYTE : 8'($urandom_range(254));
    sel = $urandom_range(199);
    // Long packets are rare so that the run stays short.
    if (sel < 3) len_req = 8'($urandom_range(255, 25));
    else if (sel < 14) len_req = 8'($urandom_range(5));
    else len_req = 8'($urandom_range(24, 6));
    full_len = (len_req < ssprx_pkg::MIN_LEN) ? ssprx_pkg::MIN_LEN : len_req;
    sel = $urandom_range(9);
    if (sel < 5) ticks = '0;
    else if (sel < 8) ticks = 16'($urandom);
    else ticks = 16'($urandom_range(12, 1));
    send_arm(id, len_req, ticks);
    while ($urandom_range(9) == 0) send_byte(8'($urandom_range(254)));
    id_byte   = ($urandom_range(99) < 88) ? id : 8'($urandom);
    len_byte  = ($urandom_range(99) < 88) ? full_len - ssprx_pkg::LEN_BIAS : 8'($urandom);
    n_payload = full_len - ssprx_pkg::MIN_LEN;
    sel = $urandom_range(99);
    if (sel < 6) begin
      // Cut short: left open until a timeout or the next arm.
      send_status_packet(id_byte, len_byte, $urandom_range(n_payload), 1'b0, 4);
      repeat ($urandom_range(15)) send_tick();
    end else begin
      send_status_packet(id_byte, len_byte, n_payload, ($urandom_range(99) < 15), 4);
      if (sel < 10) repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Nothing armed: bytes, ticks and an unknown opcode are dropped.
    send_byte(ssprx_pkg::HDR_BYTE);
    send_tick();
    send_item(OP_UNKNOWN, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF);

    // Length below the minimum is raised; empty payload, no timeout.
    send_arm(8'd0, 8'd0, 16'd0);
    send_status_packet(8'd0, ssprx_pkg::MIN_LEN - ssprx_pkg::LEN_BIAS, 0, 1'b0, 0);

    // Noise inside the header hunt, then a third 0xFF before the id.
    send_arm(8'd254, 8'd8, 16'hFFFF);
    send_byte(8'h12);
    send_byte(ssprx_pkg::HDR_BYTE);
    send_byte(8'h00);
    send_byte(ssprx_pkg::HDR_BYTE);
    send_status_packet(8'd254, 8'd4, 2, 1'b0, 0);

    // Check priority: id over length byte over checksum.
    send_arm(8'd7, 8'd7, 16'd0);
    send_status_packet(8'd8, 8'd9, 1, 1'b1, 0);
    send_arm(8'd7, 8'd7, 16'd0);
    send_status_packet(8'd7, 8'd9, 1, 1'b1, 0);
    send_arm(8'd7, 8'd7, 16'd0);
    send_status_packet(8'd7, 8'd3, 1, 1'b1, 0);

    // Timeout on the second tick; later bytes are dropped.
    send_arm(8'd1, 8'd6, 16'd2);
    send_byte(ssprx_pkg::HDR_BYTE);
    send_tick();
    send_tick();
    send_byte(ssprx_pkg::HDR_BYTE);

    // A new arm abandons an open transaction.
    send_arm(8'd3, 8'd6, 16'd0);
    send_byte(ssprx_pkg::HDR_BYTE);
    send_byte(ssprx_pkg::HDR_BYTE);
    send_byte(8'd3);
    send_arm(8'd3, 8'd6, 16'd1);
    send_status_packet(8'd3, ssprx_pkg::MIN_LEN - ssprx_pkg::LEN_BIAS, 0, 1'b0, 0);

    // Random traffic under four idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) random_transaction();
    end
    s_axis_tvalid <= 1'b0;

    // Drain the remaining results, then allow for the pipeline.
    while (board.outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (board.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
